/* design/lir_pkg.sv */
package lir_pkg;

    localparam int TIME_W          = 32;
    localparam int VAL_W           = 16;
    localparam int STEP_W          = 16;
    localparam int MAX_PER_SEG_DEF = 64;

    // divider: 32-bit partial remainder, up to 32 steps
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_INTERP = 6'd16;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD    = 6'd32;

    localparam logic [STEP_W-1:0] TIME_STEP_RESET = 16'd1;

    typedef struct packed {
        logic [TIME_W-1:0]       sample_time;
        logic signed [VAL_W-1:0] sample_value;
        logic                    end_of_record;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]       out_time;
        logic signed [VAL_W-1:0] out_value;
        logic                    last_of_run;
        logic                    segment_capped;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     rem_init;
        logic [DIV_W-1:0]     shift_init;
        logic [DIV_W-1:0]     den;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

/* design/lir_div.sv */
module lir_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  lir_pkg::div_req_t req,
    output lir_pkg::div_rsp_t rsp
);
    import lir_pkg::*;

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     sh_reg, sh_next;
    logic [DIV_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;

    logic [DIV_W:0]   cand;
    logic [DIV_W+1:0] trial;

    // one restoring step per cycle: shift in next numerator bit, try subtract
    // divisor is held for the whole operation
    always_comb begin
        cand      = {rem_reg, sh_reg[DIV_W-1]};
        trial     = {1'b0, cand} - {2'b00, den_reg};
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = req.rem_init;
            sh_next  = req.shift_init;
            den_next = req.den;
            cnt_next = req.steps;
        end else if (cnt_reg != '0) begin
            if (!trial[DIV_W+1]) begin
                rem_next = trial[DIV_W-1:0];
                sh_next  = {sh_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = cand[DIV_W-1:0];
                sh_next  = {sh_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quo  = sh_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* design/linear_interp_uniform_resampler.sv */
// an accepted item passes ST_CHECK, ST_MUL, ST_DIVS, ST_DIVW and ST_PUSH to its first result,
// each further result repeats ST_MUL to ST_PUSH, and ST_PUSH waits while the output is held;
// ST_CHECK sends a segment with no results to ST_FINISH; a capped one skips ahead via ST_SKIPS
// and ST_SKIPW; the shared restoring divider runs 16 steps per result and 32 for the skip
// an item that starts a record or closes no segment stays in ST_IDLE, the only state taking items
// reset: aresetn is synchronous and active low; it clears the record and sets time_step to 1
module linear_interp_uniform_resampler #(
    parameter int MAX_PER_SEGMENT = lir_pkg::MAX_PER_SEG_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input points
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lir_pkg::in_item_t             s_data,
    // resampled outputs
    output logic                          m_valid,
    input  logic                          m_ready,
    output lir_pkg::out_item_t            m_data,
    // time_step register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lir_pkg::STEP_W-1:0]    cfg_data
);
    import lir_pkg::*;

    localparam int CNT_W = $clog2(MAX_PER_SEGMENT + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIVS,
        ST_DIVW,
        ST_PUSH,
        ST_SKIPS,
        ST_SKIPW,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]       time_step_reg, time_step_next;
    logic [TIME_W-1:0]       prev_time_reg, prev_time_next;
    logic signed [VAL_W-1:0] prev_value_reg, prev_value_next;
    logic [TIME_W-1:0]       grid_reg, grid_next;
    logic                    have_prev_reg, have_prev_next;
    logic                    exh_reg, exh_next;

    // point being worked on
    logic [TIME_W-1:0]       cur_time_reg, cur_time_next;
    logic signed [VAL_W-1:0] cur_value_reg, cur_value_next;
    logic                    cur_eor_reg, cur_eor_next;
    logic                    dy_neg_reg, dy_neg_next;
    logic [VAL_W-1:0]        dy_mag_reg, dy_mag_next;
    logic [TIME_W+VAL_W-1:0] prod_reg, prod_next;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;
    logic [TIME_W-1:0]       res_time_reg, res_time_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [STEP_W-1:0]       step_eff;
    logic                    in_seg;
    logic                    at_cap;
    logic signed [VAL_W:0]   dy;
    logic [TIME_W:0]         grid_adv;
    logic [TIME_W:0]         grid_skip;
    logic [VAL_W+1:0]        quo_ext;
    logic [VAL_W+1:0]        val_sum;

    lir_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // zero spacing behaves as one tick
    assign step_eff = (time_step_reg == '0) ? STEP_W'(1) : time_step_reg;

    // current grid time still belongs to the open segment
    assign in_seg = !exh_reg && ((grid_reg < cur_time_reg) ||
                    ((grid_reg == cur_time_reg) && !cur_eor_reg));
    assign at_cap = (count_reg == CNT_W'(MAX_PER_SEGMENT - 1));

    assign dy = VAL_W'(0) + ({s_data.sample_value[VAL_W-1], s_data.sample_value}
              - {prev_value_reg[VAL_W-1], prev_value_reg});

    assign grid_adv  = {1'b0, grid_reg} + {{(TIME_W+1-STEP_W){1'b0}}, step_eff};
    // first grid time above the segment end: t - ((t - g) mod step) + step
    assign grid_skip = {1'b0, cur_time_reg} - {1'b0, div_rsp.rem}
                     + {{(TIME_W+1-STEP_W){1'b0}}, step_eff};

    assign quo_ext = {2'b00, div_rsp.quo[VAL_W-1:0]};
    assign val_sum = {{2{prev_value_reg[VAL_W-1]}}, prev_value_reg}
                   + (dy_neg_reg ? (~quo_ext + (VAL_W+2)'(1)) : quo_ext);

    // divider request: interpolation quotient or skip remainder
    always_comb begin
        div_req = '0;
        if (state_reg == ST_DIVS) begin
            div_req.start      = 1'b1;
            div_req.rem_init   = prod_reg[TIME_W+VAL_W-1:VAL_W];
            div_req.shift_init = {prod_reg[VAL_W-1:0], {(DIV_W-VAL_W){1'b0}}};
            div_req.den        = cur_time_reg - prev_time_reg;
            div_req.steps      = DIV_STEPS_INTERP;
        end else if (state_reg == ST_SKIPS) begin
            div_req.start      = 1'b1;
            div_req.rem_init   = '0;
            div_req.shift_init = cur_time_reg - grid_reg;
            div_req.den        = {{(DIV_W-STEP_W){1'b0}}, step_eff};
            div_req.steps      = DIV_STEPS_MOD;
        end
    end

    always_comb begin
        state_next      = state_reg;
        time_step_next  = time_step_reg;
        prev_time_next  = prev_time_reg;
        prev_value_next = prev_value_reg;
        grid_next       = grid_reg;
        have_prev_next  = have_prev_reg;
        exh_next        = exh_reg;
        cur_time_next   = cur_time_reg;
        cur_value_next  = cur_value_reg;
        cur_eor_next    = cur_eor_reg;
        dy_neg_next     = dy_neg_reg;
        dy_mag_next     = dy_mag_reg;
        prod_next       = prod_reg;
        res_value_next  = res_value_reg;
        res_time_next   = res_time_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            time_step_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_time_next  = s_data.sample_time;
                    cur_value_next = s_data.sample_value;
                    cur_eor_next   = s_data.end_of_record;
                    dy_neg_next    = dy[VAL_W];
                    dy_mag_next    = dy[VAL_W] ? VAL_W'(-dy) : dy[VAL_W-1:0];
                    count_next     = '0;
                    if (!have_prev_reg) begin
                        // first point sets the grid origin
                        prev_time_next  = s_data.sample_time;
                        prev_value_next = s_data.sample_value;
                        grid_next       = s_data.sample_time;
                        exh_next        = 1'b0;
                        have_prev_next  = !s_data.end_of_record;
                    end else if (s_data.sample_time > prev_time_reg) begin
                        state_next = ST_CHECK;
                    end else begin
                        // zero width updates the value, backward time is ignored
                        if (s_data.sample_time == prev_time_reg) begin
                            prev_value_next = s_data.sample_value;
                        end
                        if (s_data.end_of_record) begin
                            have_prev_next = 1'b0;
                            exh_next       = 1'b0;
                        end
                    end
                end
            end
            ST_CHECK: begin
                state_next = in_seg ? ST_MUL : ST_FINISH;
            end
            ST_MUL: begin
                prod_next  = dy_mag_reg * (grid_reg - prev_time_reg);
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_rsp.done) begin
                    res_value_next = val_sum[VAL_W-1:0];
                    res_time_next  = grid_reg;
                    if (grid_adv[TIME_W]) begin
                        exh_next = 1'b1;
                    end else begin
                        grid_next = grid_adv[TIME_W-1:0];
                    end
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // flags follow from the already advanced grid
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.out_time        = res_time_reg;
                    m_data_next.out_value       = res_value_reg;
                    m_data_next.last_of_run     = !in_seg || at_cap;
                    m_data_next.segment_capped  = in_seg && at_cap;
                    count_next                  = count_reg + CNT_W'(1);
                    if (!in_seg) begin
                        state_next = ST_FINISH;
                    end else if (at_cap) begin
                        state_next = ST_SKIPS;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SKIPS: begin
                state_next = ST_SKIPW;
            end
            ST_SKIPW: begin
                if (div_rsp.done) begin
                    if (grid_skip[TIME_W]) begin
                        exh_next = 1'b1;
                    end else begin
                        grid_next = grid_skip[TIME_W-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                prev_time_next  = cur_time_reg;
                prev_value_next = cur_value_reg;
                if (cur_eor_reg) begin
                    have_prev_next = 1'b0;
                    exh_next       = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            time_step_reg <= TIME_STEP_RESET;
            have_prev_reg <= 1'b0;
            exh_reg       <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            time_step_reg <= time_step_next;
            have_prev_reg <= have_prev_next;
            exh_reg       <= exh_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
        prev_time_reg  <= prev_time_next;
        prev_value_reg <= prev_value_next;
        grid_reg       <= grid_next;
        cur_time_reg   <= cur_time_next;
        cur_value_reg  <= cur_value_next;
        cur_eor_reg    <= cur_eor_next;
        dy_neg_reg     <= dy_neg_next;
        dy_mag_reg     <= dy_mag_next;
        prod_reg       <= prod_next;
        res_value_reg  <= res_value_next;
        res_time_reg   <= res_time_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

`ifndef SYNTHESIS
    // a capped segment always ends the run of results
    a_capped_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.segment_capped |-> m_data.last_of_run)
        else $error("segment_capped without last_of_run");

    // per-segment output count never passes the cap
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PER_SEGMENT))
        else $error("segment output count over cap");

    // divider is never restarted mid-operation
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // new results only come from the push step
    a_push_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_PUSH))
        else $error("result appeared outside push");
`endif

endmodule
